FILE: rtl/core/tfdt_pkg.sv
// ----------------------------------------------------------------------------
// tfdt_pkg
// Shared types and codes of the triangle fragment depth test block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfdt_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_TEST  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_WRITTEN     = 3'd0;
  localparam logic [2:0] ST_OUTSIDE_TRI = 3'd1;
  localparam logic [2:0] ST_HIDDEN      = 3'd2;
  localparam logic [2:0] ST_OUTSIDE_WIN = 3'd3;
  localparam logic [2:0] ST_UNUSABLE    = 3'd4;
  localparam logic [2:0] ST_ACCEPTED    = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_XSHIFT = 2'd2;
  localparam logic [1:0] CFG_YSHIFT = 2'd3;

  localparam int CfgW = 9;
  localparam logic [31:0] FAR_DEPTH = 32'hFFFF_FFFF;

  // arithmetic widths
  localparam int CoordW = 18;  // sign-extended coordinates and differences
  localparam int AreaW  = 38;  // signed edge areas
  localparam int MagW   = 38;  // area magnitudes, divider remainder
  localparam int QuotW  = 32;  // quotient bits per division
  localparam int AccW   = MagW + QuotW;

  localparam int NumTermsDepth = 6;  // three corners, two 16-bit halves
  localparam int NumTermsInt   = 3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         vertex_slot;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic [31:0]        vert_depth;
    logic [15:0]        vert_intensity;
    logic [7:0]         pixel_col;
    logic [7:0]         pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_col;
    logic [7:0]  out_row;
    logic [31:0] out_depth;
    logic [15:0] out_intensity;
  } out_item_t;

  typedef struct packed {
    logic       accept;
    logic       decode;
    logic       edge_mul;
    logic [1:0] edge_sel;
    logic       edge_sub;
    logic       mac_clr;
    logic       mac_mul;
    logic [2:0] mac_term;
    logic       mac_int;
    logic       mac_add;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic       fin;
    logic       push;
    logic       sweep;
  } ctrl_cmd_t;

  typedef struct packed {
    logic kind_test;
    logic sweep_last;
    logic unusable;
    logic outside_win;
    logic outside_tri;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tfdt_ram.sv
// ----------------------------------------------------------------------------
// tfdt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfdt_ram #(
  parameter int Width = 32,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/tfdt_ctrl.sv
// ----------------------------------------------------------------------------
// tfdt_ctrl
// Sequencer: store sweep, item decode, edge areas, blend and divide passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfdt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  tfdt_pkg::dp_status_t   st_i,
  output logic                   in_stall_o,
  output tfdt_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    S_SWEEP  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_EDGE   = 9'b000001000,
    S_CHECK  = 9'b000010000,
    S_MAC    = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_PUSH   = 9'b100000000
  } state_e;

  localparam logic [5:0] EDGE_LAST = 6'd4;
  localparam logic [5:0] DIV_LAST  = 6'(tfdt_pkg::QuotW + 1);

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       pass_q, pass_d;
  logic [5:0] mac_last;

  assign mac_last = pass_q ? 6'(tfdt_pkg::NumTermsInt) : 6'(tfdt_pkg::NumTermsDepth);

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    cnt_d      = cnt_q;
    pass_d     = pass_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (st_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        cnt_d        = '0;
        state_d      = st_i.kind_test ? S_EDGE : S_FIN;
      end
      S_EDGE: begin
        // products of one edge while the previous one is subtracted
        if (cnt_q < EDGE_LAST) begin
          cmd_o.edge_mul = 1'b1;
          cmd_o.edge_sel = cnt_q[1:0];
        end
        if (cnt_q != '0) begin
          cmd_o.edge_sub = 1'b1;
        end
        if (cnt_q == EDGE_LAST) begin
          state_d = S_CHECK;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_CHECK: begin
        cnt_d         = '0;
        pass_d        = 1'b0;
        cmd_o.mac_clr = 1'b1;
        if (st_i.unusable || st_i.outside_win || st_i.outside_tri) begin
          state_d = S_FIN;
        end else begin
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        cmd_o.mac_int = pass_q;
        if (cnt_q < mac_last) begin
          cmd_o.mac_mul  = 1'b1;
          cmd_o.mac_term = cnt_q[2:0];
        end
        if (cnt_q != '0) begin
          cmd_o.mac_add = 1'b1;
        end
        if (cnt_q == mac_last) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_DIV: begin
        cmd_o.mac_int = pass_q;
        if (cnt_q == '0) begin
          cmd_o.div_load = 1'b1;
          cnt_d          = cnt_q + 6'd1;
        end else if (cnt_q < DIV_LAST) begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 6'd1;
        end else begin
          cmd_o.div_store = 1'b1;
          cnt_d           = '0;
          if (pass_q) begin
            state_d = S_FIN;
          end else begin
            pass_d        = 1'b1;
            cmd_o.mac_clr = 1'b1;
            state_d       = S_MAC;
          end
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_PUSH;
      end
      S_PUSH: begin
        if (!st_i.out_busy) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == S_DECODE)
    else $error("accepted beat not decoded next cycle");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> !st_i.out_busy)
    else $error("result pushed over a stalled beat");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q <= DIV_LAST)
    else $error("divider step count overrun");

  a_second_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_store && !pass_q) |=> (pass_q && state_q == S_MAC))
    else $error("intensity pass not started after depth");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/tfdt_dp.sv
// ----------------------------------------------------------------------------
// tfdt_dp
// Datapath: config, corners, edge areas, blend accumulator, divider, store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfdt_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tfdt_pkg::in_item_t             in_data_i,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [tfdt_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                           out_stall_i,
  input  tfdt_pkg::ctrl_cmd_t            cmd_i,
  output tfdt_pkg::dp_status_t           st_o,
  output logic                           out_valid_o,
  output tfdt_pkg::out_item_t            out_data_o
);

  localparam int Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW  = $clog2(Depth);
  localparam int CW     = tfdt_pkg::CoordW;
  localparam int AW     = tfdt_pkg::AreaW;
  localparam int MW     = tfdt_pkg::MagW;
  localparam int QW     = tfdt_pkg::QuotW;
  localparam int ACW    = tfdt_pkg::AccW;
  localparam int ProdW  = MW + 16;

  function automatic logic [MW-1:0] mag(input logic signed [AW-1:0] v);
    logic [MW-1:0] r;
    r = v[AW-1] ? MW'(-v) : MW'(v);
    return r;
  endfunction

  // configuration
  logic [8:0] width_q, height_q;
  logic [7:0] xs_q, ys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      xs_q     <= 8'd128;
      ys_q     <= 8'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tfdt_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i;
        tfdt_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
        tfdt_pkg::CFG_XSHIFT: xs_q     <= cfg_wdata_i[7:0];
        tfdt_pkg::CFG_YSHIFT: ys_q     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // item register and corners
  tfdt_pkg::in_item_t item_q;
  logic signed [15:0] cx_q [3];
  logic signed [15:0] cy_q [3];
  logic [31:0]        cz_q [3];
  logic [15:0]        ci_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cx_q[i] <= '0;
        cy_q[i] <= '0;
        cz_q[i] <= '0;
        ci_q[i] <= '0;
      end
    end else if (cmd_i.decode && item_q.kind == tfdt_pkg::KIND_LOAD &&
                 item_q.vertex_slot != 2'd3) begin
      cx_q[item_q.vertex_slot] <= item_q.vert_x;
      cy_q[item_q.vertex_slot] <= item_q.vert_y;
      cz_q[item_q.vertex_slot] <= item_q.vert_depth;
      ci_q[item_q.vertex_slot] <= item_q.vert_intensity;
    end
  end

  // window and store address
  logic             in_win;
  logic [8:0]       heff;
  logic [17:0]      idx_full;
  logic [AddrW-1:0] addr;

  assign in_win = ({1'b0, item_q.pixel_col} < width_q) &&
                  (int'(item_q.pixel_col) < MAX_WIDTH) &&
                  ({1'b0, item_q.pixel_row} < height_q) &&
                  (int'(item_q.pixel_row) < MAX_HEIGHT);
  assign heff     = (int'(height_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : height_q;
  assign idx_full = 18'(item_q.pixel_row) + 18'(item_q.pixel_col) * 18'(heff);
  assign addr     = AddrW'(idx_full);

  // pixel centre, 4 fraction bits
  logic signed [8:0]    dcol, drow;
  logic signed [CW-1:0] px, py;

  assign dcol = $signed({1'b0, item_q.pixel_col}) - $signed({1'b0, xs_q});
  assign drow = $signed({1'b0, item_q.pixel_row}) - $signed({1'b0, ys_q});
  assign px   = {{(CW-13){dcol[8]}}, dcol, 4'b1000};
  assign py   = {{(CW-13){drow[8]}}, drow, 4'b1000};

  // edge unit: total area, then the three sub-areas
  logic signed [CW-1:0]   ax, ay, bx, by, qx, qy;
  logic signed [CW-1:0]   d1, d2, d3, d4;
  logic signed [2*CW-1:0] p1_q, p2_q;
  logic [1:0]             esel_q;
  logic signed [AW-1:0]   area_q [4];

  always_comb begin
    unique case (cmd_i.edge_sel)
      2'd0: begin
        ax = CW'(cx_q[0]); ay = CW'(cy_q[0]);
        bx = CW'(cx_q[1]); by = CW'(cy_q[1]);
        qx = CW'(cx_q[2]); qy = CW'(cy_q[2]);
      end
      2'd1: begin
        ax = CW'(cx_q[1]); ay = CW'(cy_q[1]);
        bx = px;           by = py;
        qx = CW'(cx_q[2]); qy = CW'(cy_q[2]);
      end
      2'd2: begin
        ax = CW'(cx_q[2]); ay = CW'(cy_q[2]);
        bx = px;           by = py;
        qx = CW'(cx_q[0]); qy = CW'(cy_q[0]);
      end
      default: begin
        ax = CW'(cx_q[0]); ay = CW'(cy_q[0]);
        bx = px;           by = py;
        qx = CW'(cx_q[1]); qy = CW'(cy_q[1]);
      end
    endcase
    d1 = bx - ax;
    d2 = qy - ay;
    d3 = by - ay;
    d4 = qx - ax;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_mul) begin
      p1_q   <= d1 * d2;
      p2_q   <= d3 * d4;
      esel_q <= cmd_i.edge_sel;
    end
    if (cmd_i.edge_sub) begin
      area_q[esel_q] <= AW'(p1_q) - AW'(p2_q);
    end
  end

  logic any_neg, any_pos;
  logic [MW-1:0] tot;
  logic [MW-1:0] wgt [3];

  assign any_neg = area_q[1][AW-1] || area_q[2][AW-1] || area_q[3][AW-1];
  assign any_pos = (!area_q[1][AW-1] && area_q[1] != '0) ||
                   (!area_q[2][AW-1] && area_q[2] != '0) ||
                   (!area_q[3][AW-1] && area_q[3] != '0);
  assign tot    = mag(area_q[0]);
  assign wgt[0] = mag(area_q[1]);
  assign wgt[1] = mag(area_q[2]);
  assign wgt[2] = mag(area_q[3]);

  // weighted sum: one 16-bit slice of a corner value per cycle
  logic [1:0]       mc;
  logic             mhi;
  logic [15:0]      mop;
  logic [ProdW-1:0] prod_q;
  logic             prodhi_q;
  logic [ACW-1:0]   acc_q;

  always_comb begin
    unique case (cmd_i.mac_term)
      3'd0: begin mc = 2'd0; mhi = 1'b0; end
      3'd1: begin mc = 2'd1; mhi = 1'b0; end
      3'd2: begin mc = 2'd2; mhi = 1'b0; end
      3'd3: begin mc = 2'd0; mhi = 1'b1; end
      3'd4: begin mc = 2'd1; mhi = 1'b1; end
      3'd5: begin mc = 2'd2; mhi = 1'b1; end
      default: begin mc = 2'd0; mhi = 1'b0; end
    endcase
    if (cmd_i.mac_int) begin
      mop = ci_q[mc];
    end else if (mhi) begin
      mop = cz_q[mc][31:16];
    end else begin
      mop = cz_q[mc][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_mul) begin
      prod_q   <= ProdW'(wgt[mc]) * ProdW'(mop);
      prodhi_q <= mhi & ~cmd_i.mac_int;
    end
    if (cmd_i.mac_clr) begin
      acc_q <= '0;
    end else if (cmd_i.mac_add) begin
      acc_q <= acc_q + (prodhi_q ? ACW'({prod_q, 16'd0}) : ACW'(prod_q));
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [MW-1:0] rem_q;
  logic [QW-1:0] dq_q;
  logic [MW:0]   r2, tx;
  logic          ge;
  logic [31:0]   dep_q;
  logic [15:0]   inten_q;

  assign r2 = {rem_q, dq_q[QW-1]};
  assign tx = {1'b0, tot};
  assign ge = r2 >= tx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= acc_q[ACW-1:QW];
      dq_q  <= acc_q[QW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= MW'(ge ? r2 - tx : r2);
      dq_q  <= {dq_q[QW-2:0], ge};
    end
    if (cmd_i.div_store) begin
      if (cmd_i.mac_int) begin
        inten_q <= (dq_q[31:16] != '0) ? 16'hFFFF : dq_q[15:0];
      end else begin
        dep_q <= dq_q;
      end
    end
  end

  // depth store with reset sweep
  logic [AddrW-1:0] sw_q;
  logic [31:0]      rd_data;
  logic             mem_we, item_we;
  logic [AddrW-1:0] mem_waddr;
  logic [31:0]      mem_wdata, item_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= '0;
    end else if (cmd_i.sweep && sw_q != AddrW'(Depth - 1)) begin
      sw_q <= sw_q + AddrW'(1);
    end
  end

  tfdt_ram #(
    .Width (32),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (cmd_i.decode),
    .raddr_i (addr),
    .rdata_o (rd_data)
  );

  // result
  tfdt_pkg::out_item_t res;
  tfdt_pkg::out_item_t res_q;
  tfdt_pkg::out_item_t out_q;
  logic                out_valid_q;
  logic                unusable;

  assign unusable = (area_q[0] == '0) || (cz_q[0] == '0) || (cz_q[1] == '0) ||
                    (cz_q[2] == '0);

  always_comb begin
    res        = '0;
    res.status = tfdt_pkg::ST_ACCEPTED;
    item_we    = 1'b0;
    item_wdata = tfdt_pkg::FAR_DEPTH;
    if (item_q.kind == tfdt_pkg::KIND_CLEAR) begin
      res.out_col = item_q.pixel_col;
      res.out_row = item_q.pixel_row;
      if (in_win) begin
        item_we = 1'b1;
      end else begin
        res.status = tfdt_pkg::ST_OUTSIDE_WIN;
      end
    end else if (item_q.kind == tfdt_pkg::KIND_TEST) begin
      res.out_col = item_q.pixel_col;
      res.out_row = item_q.pixel_row;
      priority if (unusable) begin
        res.status = tfdt_pkg::ST_UNUSABLE;
      end else if (!in_win) begin
        res.status = tfdt_pkg::ST_OUTSIDE_WIN;
      end else if (any_neg && any_pos) begin
        res.status = tfdt_pkg::ST_OUTSIDE_TRI;
      end else begin
        res.out_depth     = dep_q;
        res.out_intensity = inten_q;
        if (dep_q > rd_data) begin
          res.status = tfdt_pkg::ST_HIDDEN;
        end else begin
          res.status = tfdt_pkg::ST_WRITTEN;
          item_we    = 1'b1;
          item_wdata = dep_q;
        end
      end
    end
  end

  assign mem_we    = cmd_i.sweep || (cmd_i.fin && item_we);
  assign mem_waddr = cmd_i.sweep ? sw_q : addr;
  assign mem_wdata = cmd_i.sweep ? tfdt_pkg::FAR_DEPTH : item_wdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      res_q <= res;
    end
    if (cmd_i.push) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;
  assign st_o.kind_test   = item_q.kind == tfdt_pkg::KIND_TEST;
  assign st_o.sweep_last  = sw_q == AddrW'(Depth - 1);
  assign st_o.unusable    = unusable;
  assign st_o.outside_win = !in_win;
  assign st_o.outside_tri = any_neg && any_pos;
  assign st_o.out_busy    = out_valid_q && out_stall_i;

endmodule

`default_nettype wire

FILE: rtl/core/triangle_fragment_depth_test.sv
// ----------------------------------------------------------------------------
// triangle_fragment_depth_test
// Triangle setup store, pixel coverage, area-weighted blend and depth test.
// ----------------------------------------------------------------------------
// After reset the depth store is swept to farthest, one entry per cycle, over
// all MAX_WIDTH*MAX_HEIGHT entries; no beat is taken until then, configuration
// writes are. Load and clear beats go from accept through the decode, finish
// and push states to the result. A test beat forms its total and three sub-areas
// on a shared pair of 18x18 multipliers and, past the check, the weighted sums on
// one 38x16 multiplier, then two passes, depth and intensity, of a restoring
// one-bit-per-cycle divider. Rejected tests skip the blend and divider after
// the check. One beat is in work at a time; a finished result waits in the
// output register while the next beat is accepted.
`timescale 1ns / 1ps
`default_nettype none

module triangle_fragment_depth_test #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tfdt_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tfdt_pkg::out_item_t       out_data_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [tfdt_pkg::CfgW-1:0] cfg_wdata_i
);

  tfdt_pkg::ctrl_cmd_t  cmd;
  tfdt_pkg::dp_status_t st;

  tfdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .st_i       (st),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  tfdt_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: bench/triangle_fragment_depth_test_tb.sv
// ----------------------------------------------------------------------------
// triangle_fragment_depth_test_tb
// Self-checking bench for the triangle fragment depth test block.
// Vertex loads, pixel tests and depth clears are driven through the input
// channel under random idling and a long output hold-off. Every result beat
// is checked against a shadow triangle, window registers and depth buffer
// kept inside the bench. The window settings are changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_fragment_depth_test_tb;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] SLOT_NONE  = 2'd3;
  localparam int         GRID       = 256;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  tfdt_pkg::in_item_t            in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  tfdt_pkg::out_item_t           out_data_o;
  logic                          cfg_we_i;
  logic [1:0]                    cfg_idx_i;
  logic [tfdt_pkg::CfgW-1:0]     cfg_wdata_i;

  triangle_fragment_depth_test u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow state
  int unsigned        win_w, win_h, org_x, org_y;
  logic signed [15:0] tri_x [3];
  logic signed [15:0] tri_y [3];
  logic [31:0]        tri_z [3];
  logic [15:0]        tri_i [3];
  logic [31:0]        zbuf [GRID*GRID];

  tfdt_pkg::in_item_t  beat_queue [$];
  tfdt_pkg::out_item_t fragment_queue [$];
  int        snd_idle, rcv_idle, hold_cycles;
  bit        beat_taken;
  int        errors, results_seen, items_sent;
  int        status_seen [6];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint edge_area(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy);
    return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // floor of the area-weighted sum, split in halves so nothing overflows
  function automatic longint unsigned weigh(longint unsigned w [3], longint unsigned v [3],
                                            longint unsigned t);
    longint unsigned hi, lo, qh, rh;
    hi = 0;
    lo = 0;
    for (int k = 0; k < 3; k++) begin
      hi += w[k] * (v[k] >> 16);
      lo += w[k] * (v[k] & 64'hFFFF);
    end
    qh = hi / t;
    rh = hi % t;
    return (qh << 16) + (((rh << 16) + lo) / t);
  endfunction

  function automatic tfdt_pkg::out_item_t shade_fragment(tfdt_pkg::in_item_t it);
    tfdt_pkg::out_item_t r;
    int unsigned     weff, heff, idx;
    bit              inwin;
    longint          x [3], y [3], a [3];
    longint          tot, px, py;
    longint unsigned t, dep, inten;
    longint unsigned w [3], zv [3], iv [3];
    r = '0;
    r.status = tfdt_pkg::ST_ACCEPTED;
    weff = win_w > GRID ? GRID : win_w;
    heff = win_h > GRID ? GRID : win_h;
    inwin = it.pixel_col < weff && it.pixel_row < heff;
    idx = it.pixel_row + it.pixel_col * heff;
    case (it.kind)
      tfdt_pkg::KIND_LOAD: begin
        if (it.vertex_slot != SLOT_NONE) begin
          tri_x[it.vertex_slot] = it.vert_x;
          tri_y[it.vertex_slot] = it.vert_y;
          tri_z[it.vertex_slot] = it.vert_depth;
          tri_i[it.vertex_slot] = it.vert_intensity;
        end
      end
      tfdt_pkg::KIND_CLEAR: begin
        r.out_col = it.pixel_col;
        r.out_row = it.pixel_row;
        if (inwin && idx < GRID*GRID) zbuf[idx] = tfdt_pkg::FAR_DEPTH;
        else r.status = tfdt_pkg::ST_OUTSIDE_WIN;
      end
      tfdt_pkg::KIND_TEST: begin
        r.out_col = it.pixel_col;
        r.out_row = it.pixel_row;
        for (int k = 0; k < 3; k++) begin
          x[k] = tri_x[k];
          y[k] = tri_y[k];
        end
        tot = edge_area(x[0], y[0], x[1], y[1], x[2], y[2]);
        if (tot == 0 || tri_z[0] == 0 || tri_z[1] == 0 || tri_z[2] == 0) begin
          r.status = tfdt_pkg::ST_UNUSABLE;
        end else if (!inwin || idx >= GRID*GRID) begin
          r.status = tfdt_pkg::ST_OUTSIDE_WIN;
        end else begin
          px = (longint'(it.pixel_col) - longint'(org_x)) * 16 + 8;
          py = (longint'(it.pixel_row) - longint'(org_y)) * 16 + 8;
          a[0] = edge_area(x[1], y[1], px, py, x[2], y[2]);
          a[1] = edge_area(x[2], y[2], px, py, x[0], y[0]);
          a[2] = edge_area(x[0], y[0], px, py, x[1], y[1]);
          if ((a[0] < 0 || a[1] < 0 || a[2] < 0) &&
              (a[0] > 0 || a[1] > 0 || a[2] > 0)) begin
            r.status = tfdt_pkg::ST_OUTSIDE_TRI;
          end else begin
            t = mag(tot);
            for (int k = 0; k < 3; k++) begin
              w[k]  = mag(a[k]);
              zv[k] = tri_z[k];
              iv[k] = tri_i[k];
            end
            dep = weigh(w, zv, t);
            if (dep > 64'hFFFF_FFFF) dep = 64'hFFFF_FFFF;
            inten = weigh(w, iv, t);
            if (inten > 64'hFFFF) inten = 64'hFFFF;
            r.out_depth = dep[31:0];
            r.out_intensity = inten[15:0];
            if (dep > zbuf[idx]) begin
              r.status = tfdt_pkg::ST_HIDDEN;
            end else begin
              zbuf[idx] = dep[31:0];
              r.status = tfdt_pkg::ST_WRITTEN;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // input driver, payload held while stalled
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || beat_taken) begin
      if (beat_queue.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
        in_data_i  <= beat_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with a counted hold-off when asked
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= $urandom_range(0, 99) < rcv_idle;
    end
  end

  always @(posedge clk_i) begin
    tfdt_pkg::out_item_t want;
    beat_taken = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      beat_taken = 1'b1;
      fragment_queue.push_back(shade_fragment(in_data_i));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (fragment_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", out_data_o);
      end else begin
        want = fragment_queue.pop_front();
        if (want.status <= tfdt_pkg::ST_ACCEPTED) status_seen[want.status]++;
        if (out_data_o.status !== want.status || out_data_o.out_col !== want.out_col ||
            out_data_o.out_row !== want.out_row ||
            out_data_o.out_depth !== want.out_depth ||
            out_data_o.out_intensity !== want.out_intensity) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected st=%0d col=%0d row=%0d z=%h i=%h,",
                      " got st=%0d col=%0d row=%0d z=%h i=%h"},
                     want.status, want.out_col, want.out_row, want.out_depth,
                     want.out_intensity, out_data_o.status, out_data_o.out_col,
                     out_data_o.out_row, out_data_o.out_depth, out_data_o.out_intensity);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[tfdt_pkg::CfgW-1:0];
    case (idx)
      tfdt_pkg::CFG_WIDTH:  win_w = val & 32'h1FF;
      tfdt_pkg::CFG_HEIGHT: win_h = val & 32'h1FF;
      tfdt_pkg::CFG_XSHIFT: org_x = val & 32'hFF;
      tfdt_pkg::CFG_YSHIFT: org_y = val & 32'hFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_window(int unsigned w, int unsigned h, int unsigned xs, int unsigned ys);
    write_reg(tfdt_pkg::CFG_WIDTH, w);
    write_reg(tfdt_pkg::CFG_HEIGHT, h);
    write_reg(tfdt_pkg::CFG_XSHIFT, xs);
    write_reg(tfdt_pkg::CFG_YSHIFT, ys);
  endtask

  task automatic drain();
    while (beat_queue.size() > 0 || in_valid_i || fragment_queue.size() > 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic send(logic [1:0] kind, logic [1:0] slot, int vx, int vy,
                      logic [31:0] z, logic [15:0] inten, int col, int row);
    tfdt_pkg::in_item_t it;
    it.kind           = kind;
    it.vertex_slot    = slot;
    it.vert_x         = vx[15:0];
    it.vert_y         = vy[15:0];
    it.vert_depth     = z;
    it.vert_intensity = inten;
    it.pixel_col      = col[7:0];
    it.pixel_row      = row[7:0];
    beat_queue.push_back(it);
    items_sent++;
  endtask

  // screen coordinate near a pixel that lies in the current window
  function automatic int near_pixel(int unsigned span, int unsigned org);
    int c;
    c = $urandom_range(0, span == 0 ? 0 : span - 1);
    return (c - int'(org)) * 16 + int'($urandom_range(0, 15)) - 4;
  endfunction

  task automatic random_traffic(int n);
    int                 left, sel, tests;
    int unsigned        sw, sh, z;
    tfdt_pkg::in_item_t junk;
    sw = win_w == 0 ? 4 : (win_w > GRID ? GRID : win_w);
    sh = win_h == 0 ? 4 : (win_h > GRID ? GRID : win_h);
    left = n;
    while (left > 0) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        junk = {4'($urandom), $urandom, $urandom, $urandom};
        beat_queue.push_back(junk);
        items_sent++;
        left--;
      end else if (sel == 1) begin
        send(tfdt_pkg::KIND_CLEAR, 2'($urandom), $urandom, $urandom, $urandom,
             16'($urandom), $urandom_range(0, sw), $urandom_range(0, sh));
        left--;
      end else begin
        for (int k = 0; k < 3; k++) begin
          z = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF - $urandom_range(0, 255) : $urandom;
          if ($urandom_range(0, 15) == 0) z = 0;
          send(tfdt_pkg::KIND_LOAD, k[1:0], near_pixel(sw, org_x), near_pixel(sh, org_y), z,
               16'($urandom), $urandom, $urandom);
        end
        // occasionally reload corner 2 in place with a fixed depth and new intensity
        if ($urandom_range(0, 15) == 0)
          send(tfdt_pkg::KIND_LOAD, 2'd2, beat_queue[$].vert_x, beat_queue[$].vert_y,
               32'h1_0000, 16'($urandom), 0, 0);
        tests = $urandom_range(3, 8);
        for (int k = 0; k < tests; k++)
          send(tfdt_pkg::KIND_TEST, 2'($urandom), $urandom, $urandom, $urandom,
               16'($urandom),
               $urandom_range(0, sw + 1 > 255 ? 255 : sw + 1),
               $urandom_range(0, sh + 1 > 255 ? 255 : sh + 1));
        left -= tests + 3;
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = tfdt_pkg::CFG_WIDTH;
    cfg_wdata_i = '0;
    hold_cycles = 0;
    snd_idle    = 12;
    rcv_idle    = 64;
    win_w = 256;
    win_h = 256;
    org_x = 128;
    org_y = 128;
    for (int k = 0; k < 3; k++) begin
      tri_x[k] = '0;
      tri_y[k] = '0;
      tri_z[k] = '0;
      tri_i[k] = '0;
    end
    foreach (zbuf[k]) zbuf[k] = tfdt_pkg::FAR_DEPTH;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_window(256, 256, 128, 128);
    // directed: corners unset, so the triangle is unusable
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 128, 128);
    send(tfdt_pkg::KIND_LOAD, 2'd0, 0, 0, 32'h0002_0000, 16'h1000, 0, 0);
    send(tfdt_pkg::KIND_LOAD, 2'd1, 64, 0, 32'h0004_0000, 16'h2000, 0, 0);
    send(tfdt_pkg::KIND_LOAD, 2'd2, 0, 64, 32'h0006_0000, 16'h3000, 0, 0);
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 128, 128);
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 128, 128);  // equal depth passes
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 200, 200);  // outside the triangle
    send(tfdt_pkg::KIND_LOAD, 2'd0, 0, 0, 32'h0009_0000, 16'h1000, 0, 0);
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 128, 128);  // farther, hidden
    send(tfdt_pkg::KIND_CLEAR, 2'd0, 0, 0, 0, 0, 128, 128);
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 128, 128);
    // centre on an edge counts as inside
    send(tfdt_pkg::KIND_LOAD, 2'd1, 16, 16, 32'h0001_0000, 16'hFFFF, 0, 0);
    send(tfdt_pkg::KIND_LOAD, 2'd2, 16, 0, 32'hFFFF_FFFF, 16'hFFFF, 0, 0);
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 128, 128);
    // extreme coordinates at the limits of the corner range
    send(tfdt_pkg::KIND_LOAD, 2'd0, -32768, -32768, 32'hFFFF_FFFF, 16'hFFFF, 255, 255);
    send(tfdt_pkg::KIND_LOAD, 2'd1, 32767, -32768, 32'hFFFF_FFFF, 16'hFFFF, 255, 255);
    send(tfdt_pkg::KIND_LOAD, 2'd2, -32768, 32767, 32'hFFFF_FFFF, 16'hFFFF, 255, 255);
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 0, 0);
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 255, 255);
    send(tfdt_pkg::KIND_LOAD, SLOT_NONE, 5, 5, 0, 0, 1, 1);      // ignored slot
    send(KIND_SPARE, 2'd1, -1, -1, 32'hFFFF_FFFF, 16'hFFFF, 255, 255);
    send(tfdt_pkg::KIND_LOAD, 2'd1, 0, 0, 0, 16'h1234, 0, 0);    // zero depth corner
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 10, 10);
    send(tfdt_pkg::KIND_LOAD, 2'd1, 100, 100, 32'h10_0000, 0, 0, 0);
    send(tfdt_pkg::KIND_LOAD, 2'd2, 200, 200, 32'h10_0000, 0, 0, 0);
    send(tfdt_pkg::KIND_LOAD, 2'd0, 300, 300, 32'h10_0000, 0, 0, 0);
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 10, 10);         // collinear corners
    random_traffic(280);
    drain();

    set_window(16, 16, 8, 8);
    send(tfdt_pkg::KIND_CLEAR, 2'd0, 0, 0, 0, 0, 20, 3);          // clear outside window
    send(tfdt_pkg::KIND_TEST, 2'd0, 0, 0, 0, 0, 3, 20);           // test outside window
    random_traffic(300);
    drain();

    snd_idle = 64;
    rcv_idle = 12;
    set_window(0, 300, 0, 255);
    random_traffic(80);
    drain();
    set_window(1, 1, 255, 0);
    random_traffic(80);
    drain();
    set_window(256, 40, 20, 20);
    random_traffic(280);
    drain();

    snd_idle = 0;
    rcv_idle = 0;
    set_window(511, 256, 128, 128);
    hold_cycles = 600;
    random_traffic(220);
    drain();

    $display("covered %0d input beats and %0d results over six window settings",
             items_sent, results_seen);
    $display({"written %0d, outside tri %0d, hidden %0d, outside win %0d,",
              " unusable %0d, accepted %0d"},
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0 && fragment_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
